// File: rtl/cft_pkg.sv
package cft_pkg;

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_QUOTED  = 2'd1,
        MODE_PLAIN   = 2'd2,
        MODE_AFTERQ  = 2'd3
    } t_mode;

    localparam int          MAX_FIELDS_DEF = 255;
    localparam int          CFG_IDX_W      = 2;
    localparam logic [7:0]  NEWLINE        = 8'd10;
    localparam logic [7:0]  SPACE          = 8'd32;
    localparam logic [7:0]  TAB            = 8'd9;
    localparam logic [7:0]  CR             = 8'd13;
    localparam logic [7:0]  QUOTE_RST      = 8'd34;
    localparam logic [7:0]  SEP_RST        = 8'd44;

    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP   = 2'd1;

endpackage

// File: rtl/csv_field_tokenizer.sv
// an accepted input beat's result beat is registered and valid in the cycle after it is accepted
// one byte per cycle while o_stall is low, set by the single registered parse step
// bytes that produce no result (skipped blanks, quotes) leave no output beat
// a stalled result holds the input back only while the result register is full
// synchronous active-low reset: parse mode to between fields, counts to zero,
// quote and separator to their default bytes
module csv_field_tokenizer
    import cft_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,

    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_in_byte,

    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_char_valid,
    output logic [7:0]           o_data_char,
    output logic                 o_field_end,
    output logic                 o_row_end,
    output logic [7:0]           o_field_number,
    output logic [7:0]           o_widest_row
);

    localparam int         CAP_INT   = (MAX_FIELDS < 255) ? MAX_FIELDS : 255;
    localparam logic [7:0] FIELD_CAP = 8'(CAP_INT);

    logic [7:0] r_quote;
    logic [7:0] r_sep;
    t_mode      r_mode, n_mode;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_wide, n_wide;

    logic       r_valid;
    logic       r_char_valid;
    logic [7:0] r_data_char;
    logic       r_field_end;
    logic       r_row_end;
    logic [7:0] r_field_number;
    logic [7:0] r_widest_row;

    logic       emit;
    logic       e_char_valid;
    logic [7:0] e_data_char;
    logic       e_field_end;
    logic       e_row_end;
    logic [7:0] e_field_number;

    logic       in_acc;
    logic       blank;
    logic       with_field;
    logic [7:0] cnt_inc;
    logic [7:0] row_cnt;

    assign o_stall = r_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    assign blank   = ((i_in_byte >= TAB) && (i_in_byte <= CR)) || (i_in_byte == SPACE);
    assign cnt_inc = (r_cnt < FIELD_CAP) ? r_cnt + 8'd1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote <= QUOTE_RST;
            r_sep   <= SEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUOTE: r_quote <= i_cfg_data;
                CFG_SEP:   r_sep   <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb begin
        n_mode         = r_mode;
        n_cnt          = r_cnt;
        n_wide         = r_wide;
        emit           = 1'b0;
        e_char_valid   = 1'b0;
        e_data_char    = 8'd0;
        e_field_end    = 1'b0;
        e_row_end      = 1'b0;
        e_field_number = r_cnt;
        with_field     = (r_mode != MODE_BETWEEN);
        row_cnt        = with_field ? cnt_inc : r_cnt;

        if (i_in_byte == NEWLINE) begin
            // newline closes the row whatever the mode
            emit           = 1'b1;
            e_row_end      = 1'b1;
            e_field_end    = with_field;
            e_field_number = with_field ? r_cnt : row_cnt;
            n_wide         = (row_cnt > r_wide) ? row_cnt : r_wide;
            n_mode         = MODE_BETWEEN;
            n_cnt          = 8'd0;
        end else begin
            case (r_mode)
                MODE_BETWEEN: begin
                    if (blank) begin
                        // leading whitespace skipped
                    end else if (i_in_byte == r_quote) begin
                        n_mode = MODE_QUOTED;
                    end else if (i_in_byte == r_sep) begin
                        emit        = 1'b1;
                        e_field_end = 1'b1;
                        n_cnt       = cnt_inc;
                    end else begin
                        n_mode       = MODE_PLAIN;
                        emit         = 1'b1;
                        e_char_valid = 1'b1;
                        e_data_char  = i_in_byte;
                    end
                end
                MODE_QUOTED: begin
                    if (i_in_byte == r_quote) begin
                        n_mode = MODE_AFTERQ;
                    end else begin
                        emit         = 1'b1;
                        e_char_valid = 1'b1;
                        e_data_char  = i_in_byte;
                    end
                end
                MODE_PLAIN: begin
                    if (i_in_byte == r_sep) begin
                        emit        = 1'b1;
                        e_field_end = 1'b1;
                        n_cnt       = cnt_inc;
                        n_mode      = MODE_BETWEEN;
                    end else begin
                        emit         = 1'b1;
                        e_char_valid = 1'b1;
                        e_data_char  = i_in_byte;
                    end
                end
                MODE_AFTERQ: begin
                    if (i_in_byte == r_sep) begin
                        emit        = 1'b1;
                        e_field_end = 1'b1;
                        n_cnt       = cnt_inc;
                        n_mode      = MODE_BETWEEN;
                    end else if (i_in_byte == r_quote) begin
                        // doubled quote gives one quote byte
                        n_mode       = MODE_QUOTED;
                        emit         = 1'b1;
                        e_char_valid = 1'b1;
                        e_data_char  = r_quote;
                    end
                end
                default: begin
                    n_mode = MODE_BETWEEN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BETWEEN;
            r_cnt  <= 8'd0;
            r_wide <= 8'd0;
        end else if (in_acc) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_wide <= n_wide;
        end
    end

    // result register, refilled in the same cycle its beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_acc) begin
            r_valid <= emit;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && emit) begin
            r_char_valid   <= e_char_valid;
            r_data_char    <= e_data_char;
            r_field_end    <= e_field_end;
            r_row_end      <= e_row_end;
            r_field_number <= e_field_number;
            r_widest_row   <= n_wide;
        end
    end

    assign o_valid        = r_valid;
    assign o_char_valid   = r_char_valid;
    assign o_data_char    = r_data_char;
    assign o_field_end    = r_field_end;
    assign o_row_end      = r_row_end;
    assign o_field_number = r_field_number;
    assign o_widest_row   = r_widest_row;

    a_char_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_char_valid |-> !o_field_end && !o_row_end)
        else $error("content beat also marks a boundary");

    a_row_widest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_row_end |-> o_widest_row >= o_field_number)
        else $error("widest row below field number at row end");

    a_row_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_byte == NEWLINE) |=> (r_cnt == 8'd0) && (r_mode == MODE_BETWEEN))
        else $error("parse state not cleared after row end");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= FIELD_CAP) && (r_wide <= FIELD_CAP))
        else $error("field count beyond cap");

endmodule

// File: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cft_pkg::*;

    localparam int FIELD_CAP  = (MAX_FIELDS_DEF < 255) ? MAX_FIELDS_DEF : 255;
    localparam int N_PHASES   = 7;
    localparam int PHASE_LEN  = 190;
    localparam int DIR_ROWS   = 27;
    localparam int DRAIN_MAX  = 5000;

    // indexes the block decodes to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

    typedef struct packed {
        logic       cv;
        logic [7:0] ch;
        logic       fe;
        logic       re;
        logic [7:0] num;
        logic [7:0] wide;
    } t_token;

    typedef struct packed {
        logic [7:0] b;
        logic       lit;
        t_token     tok;
    } t_dir_row;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [7:0]           i_cfg_data = '0;
    logic                 i_valid    = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_in_byte  = '0;
    logic                 o_valid;
    logic                 i_stall    = 1'b0;
    logic                 o_char_valid;
    logic [7:0]           o_data_char;
    logic                 o_field_end;
    logic                 o_row_end;
    logic [7:0]           o_field_number;
    logic [7:0]           o_widest_row;

    csv_field_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_char_valid   (o_char_valid),
        .o_data_char    (o_data_char),
        .o_field_end    (o_field_end),
        .o_row_end      (o_row_end),
        .o_field_number (o_field_number),
        .o_widest_row   (o_widest_row)
    );

    always #2 i_clk = ~i_clk;

    // tokenizer state as the testbench sees it
    t_mode      mode_q   = MODE_BETWEEN;
    logic [7:0] fields_q = '0;
    logic [7:0] widest_q = '0;
    logic [7:0] quote_q  = QUOTE_RST;
    logic [7:0] sep_q    = SEP_RST;

    t_token     pending_tokens[$];
    logic [7:0] text_q[$];
    logic [7:0] blanks [0:4] = '{TAB, 8'd11, 8'd12, CR, SPACE};

    int  mismatches   = 0;
    int  bytes_sent   = 0;
    int  results_seen = 0;
    logic calm        = 1'b0;

    // byte, literal flag, literal token (cv ch fe re num wide)
    t_dir_row dir_tab [0:DIR_ROWS-1] = '{
        '{NEWLINE, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b1, 8'd0, 8'd0}},
        '{SEP_RST, 1'b1, '{1'b0, 8'd0,   1'b1, 1'b0, 8'd0, 8'd0}},
        '{SPACE,   1'b0, '0},
        '{TAB,     1'b0, '0},
        '{8'd97,   1'b0, '0},
        '{8'd255,  1'b1, '{1'b1, 8'd255, 1'b0, 1'b0, 8'd1, 8'd0}},
        '{8'd0,    1'b1, '{1'b1, 8'd0,   1'b0, 1'b0, 8'd1, 8'd0}},
        '{SEP_RST, 1'b1, '{1'b0, 8'd0,   1'b1, 1'b0, 8'd1, 8'd0}},
        '{CR,      1'b0, '0},
        '{QUOTE_RST, 1'b0, '0},
        '{SEP_RST, 1'b0, '0},
        '{QUOTE_RST, 1'b0, '0},
        '{QUOTE_RST, 1'b0, '0},
        '{NEWLINE, 1'b1, '{1'b0, 8'd0,   1'b1, 1'b1, 8'd2, 8'd3}},
        '{QUOTE_RST, 1'b0, '0},
        '{QUOTE_RST, 1'b0, '0},
        '{8'd120,  1'b0, '0},
        '{NEWLINE, 1'b1, '{1'b0, 8'd0,   1'b1, 1'b1, 8'd0, 8'd3}},
        '{8'd98,   1'b0, '0},
        '{CR,      1'b0, '0},
        '{SPACE,   1'b0, '0},
        '{SEP_RST, 1'b0, '0},
        '{QUOTE_RST, 1'b0, '0},
        '{8'd120,  1'b0, '0},
        '{QUOTE_RST, 1'b0, '0},
        '{SEP_RST, 1'b0, '0},
        '{NEWLINE, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b1, 8'd2, 8'd3}}
    };

    logic [7:0] quote_set [0:N_PHASES-1] = '{8'd34, 8'd0,   8'd255, 8'd7, 8'd9,  8'd39, 8'd34};
    logic [7:0] sep_set   [0:N_PHASES-1] = '{8'd44, 8'd255, 8'd0,   8'd7, 8'd32, 8'd59, 8'd44};

    function automatic t_token close_field();
        t_token t = '0;
        t.fe   = 1'b1;
        t.num  = fields_q;
        t.wide = widest_q;
        if (fields_q < FIELD_CAP) fields_q++;
        mode_q = MODE_BETWEEN;
        return t;
    endfunction

    function automatic void tokenize_byte(input logic [7:0] c, output bit has,
                                          output t_token t);
        logic [7:0] idx;
        has    = 1'b1;
        t      = '0;
        t.num  = fields_q;
        t.wide = widest_q;
        if (c == NEWLINE) begin
            idx  = fields_q;
            t.fe = (mode_q != MODE_BETWEEN);
            if (t.fe && fields_q < FIELD_CAP) fields_q++;
            if (fields_q > widest_q) widest_q = fields_q;
            t.re   = 1'b1;
            t.num  = t.fe ? idx : fields_q;
            t.wide = widest_q;
            mode_q   = MODE_BETWEEN;
            fields_q = '0;
            return;
        end
        case (mode_q)
            MODE_BETWEEN: begin
                // leading blanks win over quote and separator
                if ((c >= TAB && c <= CR) || c == SPACE) begin
                    has = 1'b0;
                end else if (c == quote_q) begin
                    mode_q = MODE_QUOTED;
                    has    = 1'b0;
                end else if (c == sep_q) begin
                    t = close_field();
                end else begin
                    mode_q = MODE_PLAIN;
                    t.cv   = 1'b1;
                    t.ch   = c;
                end
            end
            MODE_QUOTED: begin
                if (c == quote_q) begin
                    mode_q = MODE_AFTERQ;
                    has    = 1'b0;
                end else begin
                    t.cv = 1'b1;
                    t.ch = c;
                end
            end
            MODE_PLAIN: begin
                if (c == sep_q) begin
                    t = close_field();
                end else begin
                    t.cv = 1'b1;
                    t.ch = c;
                end
            end
            default: begin
                if (c == sep_q) begin
                    t = close_field();
                end else if (c == quote_q) begin
                    // doubled quote
                    mode_q = MODE_QUOTED;
                    t.cv   = 1'b1;
                    t.ch   = quote_q;
                end else begin
                    has = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic logic [7:0] content_byte(input bit quoted);
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == NEWLINE || c == quote_q || (!quoted && c == sep_q));
        return c;
    endfunction

    task automatic build_row();
        int nf;
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(255)));
            return;
        end
        nf = $urandom_range(1, 6);
        for (int f = 0; f < nf; f++) begin
            if (f != 0) text_q.push_back(sep_q);
            if ($urandom_range(3) == 0) text_q.push_back(blanks[$urandom_range(4)]);
            case ($urandom_range(9))
                0: ;
                1, 2, 3, 4: begin
                    repeat ($urandom_range(1, 6)) text_q.push_back(content_byte(1'b0));
                end
                default: begin
                    text_q.push_back(quote_q);
                    repeat ($urandom_range(0, 6)) begin
                        if ($urandom_range(6) == 0) begin
                            text_q.push_back(quote_q);
                            text_q.push_back(quote_q);
                        end else begin
                            text_q.push_back(content_byte(1'b1));
                        end
                    end
                    // now and then left open, or followed by a stray byte
                    if ($urandom_range(7) != 0) text_q.push_back(quote_q);
                    if ($urandom_range(9) == 0) text_q.push_back(content_byte(1'b0));
                end
            endcase
        end
        if ($urandom_range(7) == 0) text_q.push_back(sep_q);
        text_q.push_back(NEWLINE);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lit, input t_token lit_tok);
        bit     has;
        t_token t;
        if (!calm && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tokenize_byte(b, has, t);
        if (lit)
            pending_tokens.push_back(lit_tok);
        else if (has)
            pending_tokens.push_back(t);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_QUOTE)
            quote_q = data;
        else if (idx == CFG_SEP)
            sep_q = data;
    endtask

    task automatic drain();
        int waited = 0;
        while (pending_tokens.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        // bytes with no result may still be in flight
        repeat (4) @(posedge i_clk);
        if (pending_tokens.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, pending_tokens.size());
            mismatches += pending_tokens.size();
            pending_tokens.delete();
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= calm ? 1'b0 : ($urandom_range(99) < 32);
    end

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_char_valid, o_data_char, o_field_end, o_row_end,
                    o_field_number, o_widest_row};
            results_seen++;
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected beat cv=%0d ch=%0d fe=%0d re=%0d num=%0d wide=%0d",
                         $time, got.cv, got.ch, got.fe, got.re, got.num, got.wide);
                mismatches++;
            end else begin
                want = pending_tokens.pop_front();
                if (got.cv !== want.cv || got.ch !== want.ch || got.fe !== want.fe ||
                    got.re !== want.re || got.num !== want.num || got.wide !== want.wide) begin
                    $display("%0t: expected cv=%0d ch=%0d fe=%0d re=%0d num=%0d wide=%0d",
                             $time, want.cv, want.ch, want.fe, want.re, want.num, want.wide);
                    $display("%0t: actual   cv=%0d ch=%0d fe=%0d re=%0d num=%0d wide=%0d",
                             $time, got.cv, got.ch, got.fe, got.re, got.num, got.wide);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout after %0d bytes", bytes_sent);
        $display("csv_field_tokenizer: mismatch");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++)
            send_byte(dir_tab[k].b, dir_tab[k].lit, dir_tab[k].tok);
        i_valid <= 1'b0;
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(CFG_QUOTE, quote_set[p]);
            write_reg(CFG_SEP, sep_set[p]);
            write_reg(p[0] ? CFG_SPARE3 : CFG_SPARE2, 8'($urandom_range(255)));
            i_cfg_we <= 1'b0;
            text_q.delete();
            // in the last phase, one row long enough to saturate the field count
            if (p == N_PHASES - 1) begin
                repeat (300) text_q.push_back(sep_q);
                text_q.push_back(NEWLINE);
            end
            while (text_q.size() < PHASE_LEN) build_row();
            for (int k = 0; k < text_q.size(); k++) begin
                calm <= (k >= 60 && k < 140);
                send_byte(text_q[k], 1'b0, '0);
            end
            i_valid <= 1'b0;
            calm    <= 1'b0;
            drain();
        end

        $display("%0d bytes over %0d quote/separator settings, %0d result beats checked",
                 bytes_sent, N_PHASES + 1, results_seen);
        $display("widest row seen: %0d fields, %0d mismatches", widest_q, mismatches);
        if (mismatches == 0)
            $display("csv_field_tokenizer: match");
        else
            $display("csv_field_tokenizer: mismatch");
        $finish;
    end

endmodule
